// File: rtl/core/ins_pkg.sv
// shared types and constants for the insertion sorter
// used by ins_cell and insertion_sorter; no dependencies
`default_nettype none

package ins_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                     ins_en;
    logic                     drain;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

  // per-cell position relative to the fill count
  typedef struct packed {
    logic occupied;
    logic at_fill;
  } slot_t;

endpackage

`default_nettype wire

// File: rtl/core/insertion_sorter.sv
// top level of the insertion sorter: fill counter, drain control, output register
// depends on ins_pkg and instantiates a row of ins_cell
`default_nettype none

// Collecting takes one cycle per transaction while busy is low: every value is
// compared with all stored values at once and the cell chain shifts the larger
// ones up by one place in that same cycle. After the transaction marked last, busy
// stays high while the chain shifts one value a cycle into the output register,
// until every held value has gone out. Results appear on consecutive cycles marked
// by result_valid_o and cannot be held off. Values arriving while all CAPACITY
// cells are full are dropped and overflowed_o is set on every result of that list.
module insertion_sorter #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic signed [ins_pkg::DATA_W-1:0] value_i,
  input  wire logic                             last_i,
  output logic                                  result_valid_o,
  output logic signed [ins_pkg::DATA_W-1:0]      sorted_value_o,
  output logic                                  end_of_list_o,
  output logic                                  overflowed_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  ins_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic            dropped_q, dropped_d;
  logic            valid_q, valid_d;
  logic signed [ins_pkg::DATA_W-1:0] sorted_q, sorted_d;
  logic            end_q, end_d;
  logic            ovf_q, ovf_d;

  logic                accept;
  logic                full;
  ins_pkg::cell_ctrl_t ctrl;

  logic signed [ins_pkg::DATA_W-1:0] cell_value [CAPACITY];
  logic                              cell_greater [CAPACITY];

  assign accept = start && !busy;
  assign full   = (count_q == CW'(CAPACITY));
  assign busy   = (state_q == ins_pkg::ST_DRAIN);

  assign ctrl.ins_en = accept && !full;
  assign ctrl.drain  = busy;
  assign ctrl.value  = value_i;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    ins_pkg::slot_t                    slot;
    logic signed [ins_pkg::DATA_W-1:0] left_value;
    logic                              left_greater;
    logic signed [ins_pkg::DATA_W-1:0] right_value;

    assign slot.occupied = (CW'(k) < count_q);
    assign slot.at_fill  = (CW'(k) == count_q);

    if (k == 0) begin : g_head
      assign left_value   = '0;
      assign left_greater = 1'b0;
    end else begin : g_body
      assign left_value   = cell_value[k-1];
      assign left_greater = cell_greater[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign right_value = '0;
    end else begin : g_inner
      assign right_value = cell_value[k+1];
    end

    ins_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .slot_i         (slot),
      .left_value_i   (left_value),
      .left_greater_i (left_greater),
      .right_value_i  (right_value),
      .value_o        (cell_value[k]),
      .greater_o      (cell_greater[k])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ins_pkg::ST_COLLECT: begin
        if (accept && last_i) begin
          state_d = ins_pkg::ST_DRAIN;
        end
      end
      ins_pkg::ST_DRAIN: begin
        if (count_q == CW'(1)) begin
          state_d = ins_pkg::ST_COLLECT;
        end
      end
      default: state_d = ins_pkg::ST_COLLECT;
    endcase
  end

  // counters and result register
  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    valid_d   = 1'b0;
    sorted_d  = sorted_q;
    end_d     = end_q;
    ovf_d     = ovf_q;
    case (state_q)
      ins_pkg::ST_COLLECT: begin
        if (accept) begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            count_d = count_q + CW'(1);
          end
        end
      end
      ins_pkg::ST_DRAIN: begin
        valid_d  = 1'b1;
        sorted_d = cell_value[0];
        end_d    = (count_q == CW'(1));
        ovf_d    = dropped_q;
        count_d  = count_q - CW'(1);
        if (count_q == CW'(1)) begin
          dropped_d = 1'b0;
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ins_pkg::ST_COLLECT;
      count_q   <= '0;
      dropped_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sorted_q <= sorted_d;
    end_q    <= end_d;
    ovf_q    <= ovf_d;
  end

  assign result_valid_o = valid_q;
  assign sorted_value_o = sorted_q;
  assign end_of_list_o  = valid_q && end_q;
  assign overflowed_o   = ovf_q;

  a_result_after_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a drain cycle");

  a_count_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_drain_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (count_q != '0))
    else $error("draining an empty chain");

  a_end_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_of_list_o |-> (!busy && count_q == '0 && !dropped_q))
    else $error("state not cleared after final result");

endmodule

`default_nettype wire

// File: rtl/core/ins_cell.sv
// one compare-and-shift cell of the sorting chain
// depends on ins_pkg for the control and slot types
`default_nettype none

module ins_cell (
  input  wire logic                             clk_i,
  input  wire ins_pkg::cell_ctrl_t              ctrl_i,
  input  wire ins_pkg::slot_t                   slot_i,
  input  wire logic signed [ins_pkg::DATA_W-1:0] left_value_i,
  input  wire logic                             left_greater_i,
  input  wire logic signed [ins_pkg::DATA_W-1:0] right_value_i,
  output logic signed [ins_pkg::DATA_W-1:0]      value_o,
  output logic                                  greater_o
);

  logic signed [ins_pkg::DATA_W-1:0] value_q, value_d;

  assign greater_o = slot_i.occupied && (value_q > ctrl_i.value);
  assign value_o   = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.drain) begin
      value_d = right_value_i;
    end else if (ctrl_i.ins_en) begin
      if (left_greater_i) begin
        value_d = left_value_i;
      end else if (greater_o || slot_i.at_fill) begin
        value_d = ctrl_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for insertion_sorter: directed and random lists, results
// compared in order against a behavioural sorted-list predictor
// depends on ins_pkg and insertion_sorter
module tb_top;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS = 95;

  typedef logic signed [ins_pkg::DATA_W-1:0] word_t;

  typedef struct packed {
    word_t sorted_value;
    logic  end_of_list;
    logic  overflowed;
  } sorted_result_t;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  logic  busy;
  word_t value_i;
  logic  last_i;
  logic  result_valid_o;
  word_t sorted_value_o;
  logic  end_of_list_o;
  logic  overflowed_o;

  word_t          held_list_q[$];
  logic           list_dropped;
  sorted_result_t expected_results_q[$];
  int unsigned    mismatch_count;
  int unsigned    sender_idle_pct;

  insertion_sorter #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_i        (value_i),
    .last_i         (last_i),
    .result_valid_o (result_valid_o),
    .sorted_value_o (sorted_value_o),
    .end_of_list_o  (end_of_list_o),
    .overflowed_o   (overflowed_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // insert after every held value not greater than v; emit the list on last
  task automatic sort_and_emit(input word_t v, input logic is_last);
    int pos;
    sorted_result_t res;
    if (held_list_q.size() < CAPACITY) begin
      pos = held_list_q.size();
      while (pos > 0 && held_list_q[pos-1] > v) pos--;
      held_list_q.insert(pos, v);
    end else begin
      list_dropped = 1'b1;
    end
    if (is_last) begin
      for (int k = 0; k < held_list_q.size(); k++) begin
        res.sorted_value = held_list_q[k];
        res.end_of_list  = (k == held_list_q.size() - 1);
        res.overflowed   = list_dropped;
        expected_results_q.push_back(res);
      end
      held_list_q.delete();
      list_dropped = 1'b0;
    end
  endtask

  task automatic send_item(input word_t v, input logic is_last);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    value_i <= v;
    last_i  <= is_last;
    do @(posedge clk_i); while (busy);
    sort_and_emit(v, is_last);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (expected_results_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  function automatic word_t pick_value();
    word_t v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = '0;
          default: v = '1;
        endcase
      end
      1, 2, 3: begin
        v = $urandom_range(16);
        v = v - 8;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_random_list(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(pick_value(), i == len - 1);
  endtask

  task automatic test_extremes();
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh0000_0000, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sh8000_0001, 1'b1);
  endtask

  task automatic test_single_item_lists();
    send_item(32'sh5555_5555, 1'b1);
    send_item(32'shAAAA_AAAA, 1'b1);
  endtask

  task automatic test_equal_values();
    send_item(32'sd5, 1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(32'sd5, 1'b1);
  endtask

  task automatic test_ordered_input();
    for (int i = 0; i < 4; i++) send_item(i * 1000 - 1500, i == 3);
    for (int i = 0; i < 4; i++) send_item(1500 - i * 1000, i == 3);
  endtask

  // exactly full, dropped final item, and several dropped items
  task automatic test_overflow();
    send_random_list(CAPACITY);
    send_random_list(CAPACITY + 1);
    wait_results_drained();
    send_random_list(CAPACITY + 6);
  endtask

  task automatic test_random_lists(input int unsigned idle_pct, input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(14) == 0) len = $urandom_range(CAPACITY + 8, CAPACITY - 4);
      else len = $urandom_range(12, 1);
      send_random_list(len);
      sent += len;
      if ($urandom_range(7) == 0) wait_results_drained();
    end
    wait_results_drained();
  endtask

  always @(posedge clk_i) begin
    sorted_result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_results_q.size() == 0) begin
        $display("%0t: unexpected result, got value %0d eol %0b ovf %0b", $time,
                 sorted_value_o, end_of_list_o, overflowed_o);
        mismatch_count++;
      end else begin
        want = expected_results_q.pop_front();
        if (sorted_value_o !== want.sorted_value) begin
          $display("%0t: sorted_value expected %0d, got %0d", $time,
                   want.sorted_value, sorted_value_o);
          mismatch_count++;
        end
        if (end_of_list_o !== want.end_of_list) begin
          $display("%0t: end_of_list expected %0b, got %0b", $time,
                   want.end_of_list, end_of_list_o);
          mismatch_count++;
        end
        if (overflowed_o !== want.overflowed) begin
          $display("%0t: overflowed expected %0b, got %0b", $time,
                   want.overflowed, overflowed_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2400000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    mismatch_count  = 0;
    list_dropped    = 1'b0;
    sender_idle_pct = 14;
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    value_i <= '0;
    last_i  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_single_item_lists();
    test_equal_values();
    test_ordered_input();
    wait_results_drained();
    test_overflow();
    wait_results_drained();
    test_random_lists(14, PHASE_ITEMS);
    test_random_lists(76, PHASE_ITEMS);
    test_random_lists(0, PHASE_ITEMS);

    if (mismatch_count == 0 && held_list_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
